>>> rtl/core/ljpf_pkg.sv
// ----------------------------------------------------------------------------
// ljpf_pkg
// Shared widths, register indexes and constants of the Lennard-Jones pair
// force pipeline.
// ----------------------------------------------------------------------------
package ljpf_pkg;

   localparam int DIST_FRAC_BITS_DEF = 16;
   localparam int DIST_W  = 24;
   localparam int EPS_W   = 32;
   localparam int RES_W   = 40;
   localparam int WORD_W  = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_WELL_DEPTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_DISTANCE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_DISTANCE = 2'd2;

   // saturation value of an intermediate product
   localparam logic [WORD_W-1:0] CAP    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [RES_W-1:0]  POSMAX = 40'h7F_FFFF_FFFF;
   localparam logic [WORD_W-1:0] NEGMAG = 64'h0000_0080_0000_0000;

endpackage

>>> rtl/core/ljpf_pipe.sv
// ----------------------------------------------------------------------------
// ljpf_pipe
// Fixed-length delay line for side data riding along the datapath.
// ----------------------------------------------------------------------------
module ljpf_pipe #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] tap_ff [N];

   always_ff @(posedge clock) begin
      tap_ff[0] <= d;
      for (int i = 1; i < N; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign q = tap_ff[N-1];

endmodule

>>> rtl/core/ljpf_div.sv
// ----------------------------------------------------------------------------
// ljpf_div
// Pipelined restoring divider, one quotient bit per stage. The dividend
// is a quasi-static value read at each stage.
// ----------------------------------------------------------------------------
module ljpf_div #(
   parameter int NW = 56,
   parameter int DW = 26
) (
   input  logic          clock,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo
);

   logic [DW-1:0] rem_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [NW-1:0] quo_ff [NW];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [DW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [NW-1:0] quo_prev;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;

      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      assign trial = {rem_prev, num[NW-1-i]};
      assign ge    = trial >= {1'b0, den_prev};
      assign diff  = trial - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         rem_ff[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
         den_ff[i] <= den_prev;
         quo_ff[i] <= {quo_prev[NW-2:0], ge};
      end
   end

   assign quo = quo_ff[NW-1];

endmodule

>>> rtl/core/ljpf_mul.sv
// ----------------------------------------------------------------------------
// ljpf_mul
// 64x64 multiply, shift right by a constant, saturate at 2^63-1.
// Three stages: partial products, sum, shift and overflow check.
// ----------------------------------------------------------------------------
module ljpf_mul
   import ljpf_pkg::*;
#(
   parameter int SHIFT = 32
) (
   input  logic              clock,
   input  logic [WORD_W-1:0] a,
   input  logic [WORD_W-1:0] b,
   input  logic              ovf_i,
   output logic [WORD_W-1:0] r,
   output logic              ovf_o
);

   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic         ovf1_ff, ovf2_ff, ovf3_ff;
   logic [127:0] prod_in, prod_ff, sh;
   logic         big;
   logic [63:0]  r_ff;

   always_ff @(posedge clock) begin
      ll_ff   <= {32'b0, a[31:0]}  * {32'b0, b[31:0]};
      lh_ff   <= {32'b0, a[31:0]}  * {32'b0, b[63:32]};
      hl_ff   <= {32'b0, a[63:32]} * {32'b0, b[31:0]};
      hh_ff   <= {32'b0, a[63:32]} * {32'b0, b[63:32]};
      ovf1_ff <= ovf_i;
   end

   assign prod_in = {hh_ff, 64'b0} + {32'b0, lh_ff, 32'b0}
                  + {32'b0, hl_ff, 32'b0} + {64'b0, ll_ff};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ovf2_ff <= ovf1_ff;
   end

   assign sh  = prod_ff >> SHIFT;
   assign big = |sh[127:63];

   always_ff @(posedge clock) begin
      r_ff    <= big ? CAP : {1'b0, sh[62:0]};
      ovf3_ff <= ovf2_ff | big;
   end

   assign r     = r_ff;
   assign ovf_o = ovf3_ff;

endmodule

>>> rtl/core/lennard_jones_pair_force_top.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_top
// Lennard-Jones 12-6 pair energy and force, fully pipelined fixed point.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  --------+--------------------------------+---------------------------
//  request | start, busy, req_*             | word taken on start && !busy
//  result  | rsp_strobe, rsp_*              | one-cycle strobe per word, no stall
//  config  | csr_valid, csr_ready, csr_*    | written on valid && ready
//
// One pair enters every cycle; busy stays low. The path to the strobe runs
// through the input register, the bit-per-stage divider, seven chained
// three-stage multiply units, the difference register and the output
// register, with NW = max(56, DIST_FRAC_BITS + 33) as the divider width.
// Reset clears the valid chain, the strobe and the configuration registers; nothing in flight survives.
// The receiver cannot stall, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_top
   import ljpf_pkg::*;
#(
   parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DIST_W-1:0]     req_distance,
   input  logic signed [DIST_W-1:0] req_delta_x,
   input  logic signed [DIST_W-1:0] req_delta_y,
   input  logic signed [DIST_W-1:0] req_delta_z,
   output logic                  rsp_strobe,
   output logic                  rsp_within_cutoff,
   output logic signed [RES_W-1:0] rsp_energy,
   output logic signed [RES_W-1:0] rsp_force_x,
   output logic signed [RES_W-1:0] rsp_force_y,
   output logic signed [RES_W-1:0] rsp_force_z,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int F    = DIST_FRAC_BITS;
   localparam int DR_W = (F + 2 > DIST_W) ? F + 2 : DIST_W;
   localparam int NW   = (F + 33 > 56) ? F + 33 : 56;
   localparam int LAT  = NW + 24;
   localparam logic [DR_W-1:0] TWO_DR = DR_W'(1) << (F + 1);

   // ---------------- configuration
   logic [EPS_W-1:0]  eps_ff;
   logic [DIST_W-1:0] sigma_ff, cutoff_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff    <= '0;
         sigma_ff  <= '0;
         cutoff_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WELL_DEPTH:      eps_ff    <= csr_data;
            CSR_ZERO_DISTANCE:   sigma_ff  <= csr_data[DIST_W-1:0];
            CSR_CUTOFF_DISTANCE: cutoff_ff <= csr_data[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // ---------------- input stage
   logic              acc;
   logic              valid0_ff, within0_ff;
   logic [DR_W-1:0]   dist_ext, dr0_ff;
   logic [DIST_W-1:0] dmag0_ff [3];
   logic [2:0]        dneg0_ff, dzero0_ff;
   logic [DIST_W-1:0] draw [3];

   assign acc      = start && !busy;
   assign dist_ext = DR_W'(req_distance);
   assign draw[0]  = req_delta_x;
   assign draw[1]  = req_delta_y;
   assign draw[2]  = req_delta_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      within0_ff <= req_distance <= cutoff_ff;
      dr0_ff     <= (dist_ext < TWO_DR) ? TWO_DR : dist_ext;
      for (int j = 0; j < 3; j++) begin
         dneg0_ff[j]  <= draw[j][DIST_W-1];
         dzero0_ff[j] <= draw[j] == '0;
         dmag0_ff[j]  <= draw[j][DIST_W-1] ? (~draw[j] + 1'b1) : draw[j];
      end
   end

   // ---------------- dividers: p = sigma*2^32/dr, inv = 2^(F+32)/dr
   logic [NW-1:0] num_p, num_inv, p_q, inv_q;

   assign num_p   = NW'({sigma_ff, 32'b0});
   assign num_inv = NW'(1) << (F + 32);

   ljpf_div #(.NW(NW), .DW(DR_W)) u_div_p (
      .clock(clock), .num(num_p), .den(dr0_ff), .quo(p_q)
   );
   ljpf_div #(.NW(NW), .DW(DR_W)) u_div_inv (
      .clock(clock), .num(num_inv), .den(dr0_ff), .quo(inv_q)
   );

   // ---------------- powers of p
   logic [WORD_W-1:0] p_w, inv_w, p2, p2_d, p4, p6, p12, inv2, inv2_d;
   logic              p2_o, p4_o, p6_o, p12_o, inv2_o, inv2_o_d;

   assign p_w   = WORD_W'(p_q);
   assign inv_w = WORD_W'(inv_q);

   ljpf_mul #(.SHIFT(32)) u_p2 (
      .clock(clock), .a(p_w), .b(p_w), .ovf_i(1'b0), .r(p2), .ovf_o(p2_o)
   );
   ljpf_mul #(.SHIFT(32)) u_inv2 (
      .clock(clock), .a(inv_w), .b(inv_w), .ovf_i(1'b0), .r(inv2), .ovf_o(inv2_o)
   );
   ljpf_mul #(.SHIFT(32)) u_p4 (
      .clock(clock), .a(p2), .b(p2), .ovf_i(p2_o), .r(p4), .ovf_o(p4_o)
   );
   ljpf_pipe #(.W(WORD_W), .N(3)) u_p2_dly (.clock(clock), .d(p2), .q(p2_d));
   ljpf_mul #(.SHIFT(32)) u_p6 (
      .clock(clock), .a(p4), .b(p2_d), .ovf_i(p4_o), .r(p6), .ovf_o(p6_o)
   );
   ljpf_mul #(.SHIFT(32)) u_p12 (
      .clock(clock), .a(p6), .b(p6), .ovf_i(p6_o), .r(p12), .ovf_o(p12_o)
   );
   ljpf_pipe #(.W(WORD_W + 1), .N(13)) u_inv2_dly (
      .clock(clock), .d({inv2_o, inv2}), .q({inv2_o_d, inv2_d})
   );

   // ---------------- differences p12-p6 and 2*p12-p6
   logic [WORD_W-1:0] p6_d, twice;
   logic [WORD_W-1:0] emag_ff, tmag_ff;
   logic              eneg_ff, tneg_ff, povf_ff;

   ljpf_pipe #(.W(WORD_W), .N(3)) u_p6_dly (.clock(clock), .d(p6), .q(p6_d));

   assign twice = {p12[WORD_W-2:0], 1'b0};

   always_ff @(posedge clock) begin
      eneg_ff <= p6_d > p12;
      emag_ff <= (p6_d > p12) ? p6_d - p12 : p12 - p6_d;
      tneg_ff <= p6_d > twice;
      tmag_ff <= (p6_d > twice) ? p6_d - twice : twice - p6_d;
      povf_ff <= p12_o;
   end

   // ---------------- energy and force coefficient
   logic [WORD_W-1:0] eps_w, eps24, e_mul, k, c;
   logic              e_o, k_o, c_o;

   assign eps_w = WORD_W'(eps_ff);
   assign eps24 = (eps_w << 4) + (eps_w << 3);

   ljpf_mul #(.SHIFT(30)) u_emag (
      .clock(clock), .a(eps_w), .b(emag_ff), .ovf_i(1'b0), .r(e_mul), .ovf_o(e_o)
   );
   ljpf_mul #(.SHIFT(32)) u_k (
      .clock(clock), .a(eps24), .b(tmag_ff), .ovf_i(povf_ff), .r(k), .ovf_o(k_o)
   );
   ljpf_mul #(.SHIFT(32)) u_c (
      .clock(clock), .a(k), .b(inv2_d), .ovf_i(k_o | inv2_o_d), .r(c), .ovf_o(c_o)
   );

   // ---------------- force magnitudes
   logic [DIST_W-1:0] dmag_d [3];
   logic [WORD_W-1:0] fmag [3];
   logic [2:0]        fovf;

   for (genvar j = 0; j < 3; j++) begin : g_axis
      logic [WORD_W-1:0] dmag_w;
      ljpf_pipe #(.W(DIST_W), .N(NW + 19)) u_dmag_dly (
         .clock(clock), .d(dmag0_ff[j]), .q(dmag_d[j])
      );
      assign dmag_w = WORD_W'(dmag_d[j]);
      ljpf_mul #(.SHIFT(F)) u_fmag (
         .clock(clock), .a(c), .b(dmag_w), .ovf_i(c_o), .r(fmag[j]), .ovf_o(fovf[j])
      );
   end

   // ---------------- side data aligned to the final stage
   logic        within_d;
   logic [2:0]  dneg_d, dzero_d;
   logic        eneg_d, tneg_d, tzero_d, povf_d, e_o_d;
   logic [WORD_W-1:0] e_mul_d;

   ljpf_pipe #(.W(7), .N(NW + 22)) u_side_dly (
      .clock(clock), .d({within0_ff, dneg0_ff, dzero0_ff}),
      .q({within_d, dneg_d, dzero_d})
   );
   ljpf_pipe #(.W(4), .N(9)) u_sign_dly (
      .clock(clock), .d({eneg_ff, tneg_ff, tmag_ff == '0, povf_ff}),
      .q({eneg_d, tneg_d, tzero_d, povf_d})
   );
   ljpf_pipe #(.W(WORD_W + 1), .N(6)) u_e_dly (
      .clock(clock), .d({e_o, e_mul}), .q({e_o_d, e_mul_d})
   );

   // valid chain, cleared by reset
   logic [NW+21:0] vchain_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vchain_ff <= '0;
      end else begin
         vchain_ff <= {vchain_ff[NW+20:0], valid0_ff};
      end
   end

   // ---------------- output stage
   function automatic logic [RES_W-1:0] pack40(input logic neg,
                                               input logic [WORD_W-1:0] mag,
                                               input logic ovf);
      logic [WORD_W-1:0] m;
      m = mag;
      if (mag == '0 && !ovf) begin
         return '0;
      end
      if (neg) begin
         if (ovf || mag > NEGMAG) m = NEGMAG;
         return ~m[RES_W-1:0] + 1'b1;
      end
      if (ovf || mag > WORD_W'(POSMAX)) return POSMAX;
      return m[RES_W-1:0];
   endfunction

   logic             strobe_ff, within_ff;
   logic [RES_W-1:0] energy_in, energy_ff;
   logic [RES_W-1:0] force_in [3];
   logic [RES_W-1:0] force_ff [3];
   logic             live;

   assign live = within_d && (eps_ff != '0);

   always_comb begin
      priority if (!live) begin
         energy_in = '0;
      end else if (povf_d) begin
         energy_in = POSMAX;
      end else begin
         energy_in = pack40(eneg_d, e_mul_d, e_o_d);
      end
      for (int j = 0; j < 3; j++) begin
         // outside cutoff, zero well depth, zero displacement, or zero coefficient without overflow, gives 0
         if (!live || dzero_d[j] || (tzero_d && !povf_d)) begin
            force_in[j] = '0;
         end else begin
            force_in[j] = pack40(tneg_d ^ dneg_d[j], fmag[j], fovf[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vchain_ff[NW+21];
      end
   end

   always_ff @(posedge clock) begin
      within_ff <= within_d;
      energy_ff <= energy_in;
      for (int j = 0; j < 3; j++) begin
         force_ff[j] <= force_in[j];
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_within_cutoff = within_ff;
   assign rsp_energy        = energy_ff;
   assign rsp_force_x       = force_ff[0];
   assign rsp_force_y       = force_ff[1];
   assign rsp_force_z       = force_ff[2];

   // ---------------- assertions
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("result word missing at pipeline depth");

   a_cutoff_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_within_cutoff) |->
         (rsp_energy == '0 && rsp_force_x == '0 && rsp_force_y == '0 &&
          rsp_force_z == '0))
      else $error("nonzero result beyond cutoff");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(vchain_ff[NW+21]))
      else $error("strobe without an item in flight");

endmodule
